// File: rtl/dms_pkg.sv
// Shared types and constants for the dispense motor sequencer.
// Used by dms_cfg_regs, dms_divider and dispense_motor_sequencer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

  // Operating modes, encoded as they appear on the result stream
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_DISP  = 3'd1,
    MODE_RET   = 3'd2,
    MODE_MAINT = 3'd3,
    MODE_DIS   = 3'd4
  } mode_t;

  // Motor direction codes
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_READY  = 1'b0,
    ST_DIVIDE = 1'b1
  } seq_state_t;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MAX_STOCK     = 2'd0,
    REG_RETURN_SPEED  = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2,
    REG_INITIAL_STOCK = 2'd3
  } reg_idx_t;

  // Sensor flag bit positions
  localparam int unsigned FLAG_TOP    = 0;
  localparam int unsigned FLAG_EXIT   = 1;
  localparam int unsigned FLAG_BOTTOM = 2;

  // Lift speed mapping
  localparam logic [7:0]  SPEED_LOW  = 8'd50;
  localparam logic [15:0] SPEED_SPAN = 16'd190;

  // Register reset values
  localparam logic [7:0]  MAX_STOCK_RST     = 8'd10;
  localparam logic [7:0]  RETURN_SPEED_RST  = 8'd50;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd6000;
  localparam logic [7:0]  INIT_STOCK_RST    = 8'd0;

  // Division width
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned DIV_CW  = $clog2(DIV_W + 1);

  // Configuration bundle from the register block
  typedef struct packed {
    logic [7:0]  max_stock;
    logic [7:0]  return_speed;
    logic [15:0] timeout_ticks;
    logic [7:0]  initial_stock;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/dms_cfg_regs.sv
// APB configuration registers of the dispense motor sequencer.
// Depends on dms_pkg (cfg_t, reg_idx_t, reset values).
`timescale 1ns / 1ps
`default_nettype none

module dms_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output dms_pkg::cfg_t      cfg
);

  logic             wr_en;
  dms_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = dms_pkg::reg_idx_t'(paddr[3:2]);

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_stock     <= dms_pkg::MAX_STOCK_RST;
      cfg.return_speed  <= dms_pkg::RETURN_SPEED_RST;
      cfg.timeout_ticks <= dms_pkg::TIMEOUT_TICKS_RST;
      cfg.initial_stock <= dms_pkg::INIT_STOCK_RST;
    end else if (wr_en) begin
      case (idx)
        dms_pkg::REG_MAX_STOCK:     cfg.max_stock     <= pwdata[7:0];
        dms_pkg::REG_RETURN_SPEED:  cfg.return_speed  <= pwdata[7:0];
        dms_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[15:0];
        dms_pkg::REG_INITIAL_STOCK: cfg.initial_stock <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      dms_pkg::REG_MAX_STOCK:     prdata = {24'd0, cfg.max_stock};
      dms_pkg::REG_RETURN_SPEED:  prdata = {24'd0, cfg.return_speed};
      dms_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, cfg.timeout_ticks};
      dms_pkg::REG_INITIAL_STOCK: prdata = {24'd0, cfg.initial_stock};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/dms_divider.sv
// Restoring divider, one quotient bit per cycle, for the lift speed mapping.
// Depends on dms_pkg (DIV_W, DIV_CW).
`timescale 1ns / 1ps
`default_nettype none

module dms_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [dms_pkg::DIV_W-1:0] dividend,
  input  wire logic [7:0]                divisor,
  output logic                           busy,
  output logic      [dms_pkg::DIV_W-1:0] quotient
);

  logic [dms_pkg::DIV_CW-1:0] cnt;
  logic [7:0]                 rem;
  logic [8:0]                 shift_in;
  logic                       q_bit;
  logic [8:0]                 diff;

  assign busy = (cnt != '0);

  // Bring down the next dividend bit and try a subtract
  always_comb begin
    shift_in = {rem, quotient[dms_pkg::DIV_W-1]};
    diff     = shift_in - {1'b0, divisor};
    q_bit    = (shift_in >= {1'b0, divisor});
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= dms_pkg::DIV_CW'(dms_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= q_bit ? diff[7:0] : shift_in[7:0];
      quotient <= {quotient[dms_pkg::DIV_W-2:0], q_bit};
    end
  end

endmodule

`default_nettype wire

// File: rtl/dispense_motor_sequencer.sv
// Top level of the dispense motor sequencer: tick sequencer, result register.
// Depends on dms_pkg, dms_cfg_regs and dms_divider.
`timescale 1ns / 1ps
`default_nettype none

// One request on s_* is one poll tick; each tick yields exactly one result on
// m_*. A tick's result appears in the cycle after acceptance, except for a
// payment tick seen in idle mode, which waits in ST_DIVIDE: the lift speed is
// (stock-1)*190/(max_stock-1)+50, and its quotient comes from a restoring
// divider that produces one bit per cycle. The block holds off a new tick
// while the previous result still waits on m_tready. Configuration goes
// through the APB port; the user must write it only while idle (not enforced).
module dispense_motor_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Tick stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [0] payment_ok [1] top_hit [2] exit_hit [3] bottom_hit [4] service_press
  // [5] up_held [6] down_held [7] add_press [8] sub_press, rest zero
  input  wire logic [15:0] s_tdata,
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] mode [4:3] motor_dir [12:5] motor_duty [20:13] stock [21] save_req
  // [22] fault [23] zero
  output logic      [23:0] m_tdata
);

  dms_pkg::cfg_t       cfg;
  dms_pkg::seq_state_t st, st_next;

  // Tick state
  dms_pkg::mode_t mode_reg, mode_next, mode_tmp;
  dms_pkg::dir_t  dir_reg, dir_next;
  logic [7:0]     lift_speed, lift_speed_next;
  logic [7:0]     stock_count, stock_count_next;
  logic [15:0]    elapsed, elapsed_next, el_inc;
  logic [2:0]     sensor_flags, sensor_flags_next;

  // Held tick while the divider runs
  logic [8:0] item_hold;
  logic [8:0] item;

  logic        s_accept, out_free, need_div, commit;
  logic        save_req, fault, both;
  logic [7:0]  duty, speed_map, s_clamp;
  logic        div_busy;
  logic [15:0] div_quo, dividend;
  logic [7:0]  divisor;

  dms_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake and sequencing control
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (st == dms_pkg::ST_READY) && out_free;
  assign s_accept = s_tvalid && s_tready;
  assign need_div = (mode_reg == dms_pkg::MODE_IDLE) && s_tdata[0];
  assign item     = (st == dms_pkg::ST_READY) ? s_tdata[8:0] : item_hold;

  always_comb begin
    st_next = st;
    commit  = 1'b0;
    case (st)
      dms_pkg::ST_READY: begin
        if (s_accept && need_div) st_next = dms_pkg::ST_DIVIDE;
        else if (s_accept)        commit  = 1'b1;
      end
      dms_pkg::ST_DIVIDE: begin
        if (!div_busy && out_free) begin
          commit  = 1'b1;
          st_next = dms_pkg::ST_READY;
        end
      end
      default: st_next = dms_pkg::ST_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= dms_pkg::ST_READY;
    else     st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (s_accept) item_hold <= s_tdata[8:0];
  end

  // Clamp stock into [1, max_stock] and scale by the speed span
  always_comb begin
    if (stock_count == 8'd0)               s_clamp = 8'd1;
    else if (stock_count > cfg.max_stock)  s_clamp = cfg.max_stock;
    else                                   s_clamp = stock_count;
    dividend = 16'(s_clamp - 8'd1) * dms_pkg::SPEED_SPAN;
    divisor  = cfg.max_stock - 8'd1;
  end

  dms_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (s_accept && need_div),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign speed_map = (cfg.max_stock < 8'd2) ? dms_pkg::SPEED_LOW
                                            : div_quo[7:0] + dms_pkg::SPEED_LOW;

  // Per-tick mode machine
  always_comb begin
    mode_next         = mode_reg;
    mode_tmp          = mode_reg;
    dir_next          = dir_reg;
    lift_speed_next   = lift_speed;
    stock_count_next  = stock_count;
    elapsed_next      = elapsed;
    sensor_flags_next = sensor_flags;
    save_req          = 1'b0;
    fault             = 1'b0;
    both   = sensor_flags[dms_pkg::FLAG_TOP] & sensor_flags[dms_pkg::FLAG_EXIT];
    el_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
    case (mode_reg)
      dms_pkg::MODE_IDLE: begin
        if (item[0]) begin
          mode_next         = dms_pkg::MODE_DISP;
          lift_speed_next   = speed_map;
          elapsed_next      = 16'd0;
          sensor_flags_next = 3'd0;
          dir_next          = dms_pkg::DIR_UP;
        end
        if (stock_count == 8'd0) begin
          mode_next = dms_pkg::MODE_DIS;
          fault     = 1'b1;
        end
        if (item[4]) mode_next = dms_pkg::MODE_MAINT;
      end
      dms_pkg::MODE_DISP: begin
        elapsed_next = el_inc;
        if (el_inc < cfg.timeout_ticks && !both) begin
          if (item[1]) begin
            dir_next = dms_pkg::DIR_STOP;
            sensor_flags_next[dms_pkg::FLAG_TOP] = 1'b1;
          end
          if (item[2]) sensor_flags_next[dms_pkg::FLAG_EXIT] = 1'b1;
        end else begin
          dir_next = dms_pkg::DIR_DOWN;
          if (both) begin
            mode_next = dms_pkg::MODE_RET;
            if (stock_count != 8'd0) stock_count_next = stock_count - 8'd1;
            save_req = 1'b1;
          end else begin
            mode_next = dms_pkg::MODE_DIS;
            fault     = 1'b1;
          end
        end
      end
      dms_pkg::MODE_RET: begin
        if (item[3]) begin
          sensor_flags_next[dms_pkg::FLAG_BOTTOM] = 1'b1;
          dir_next  = dms_pkg::DIR_STOP;
          mode_next = dms_pkg::MODE_IDLE;
        end
      end
      dms_pkg::MODE_MAINT: begin
        if (item[5])      dir_next = dms_pkg::DIR_UP;
        else if (item[6]) dir_next = dms_pkg::DIR_DOWN;
        else              dir_next = dms_pkg::DIR_STOP;
        if (item[7] && stock_count < cfg.max_stock) stock_count_next = stock_count + 8'd1;
        if (item[8] && stock_count_next != 8'd0)
          stock_count_next = stock_count_next - 8'd1;
        if (item[4]) begin
          mode_next         = dms_pkg::MODE_IDLE;
          sensor_flags_next = 3'd0;
          save_req          = 1'b1;
        end
      end
      default: begin
        // Disabled: service button leads to maintenance, or to idle with a first bottom hit, which stops the motor
        mode_tmp = item[4] ? dms_pkg::MODE_MAINT : dms_pkg::MODE_DIS;
        if (!sensor_flags[dms_pkg::FLAG_BOTTOM] && item[3]) begin
          sensor_flags_next[dms_pkg::FLAG_BOTTOM] = 1'b1;
          dir_next = dms_pkg::DIR_STOP;
          if (mode_tmp != dms_pkg::MODE_DIS) mode_tmp = dms_pkg::MODE_IDLE;
        end
        mode_next = mode_tmp;
      end
    endcase
    case (dir_next)
      dms_pkg::DIR_UP:   duty = lift_speed_next;
      dms_pkg::DIR_DOWN: duty = cfg.return_speed;
      default:           duty = 8'd0;
    endcase
  end

  // Commit tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= dms_pkg::MODE_IDLE;
      dir_reg      <= dms_pkg::DIR_STOP;
      lift_speed   <= 8'd0;
      stock_count  <= dms_pkg::INIT_STOCK_RST;
      elapsed      <= 16'd0;
      sensor_flags <= 3'd0;
    end else if (commit) begin
      mode_reg     <= mode_next;
      dir_reg      <= dir_next;
      lift_speed   <= lift_speed_next;
      stock_count  <= stock_count_next;
      elapsed      <= elapsed_next;
      sensor_flags <= sensor_flags_next;
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {1'b0, fault, save_req, stock_count_next, duty, dir_next, mode_next};
    end
  end

  // The divider only runs while a payment tick is held
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (st == dms_pkg::ST_READY) |-> !div_busy)
    else $error("divider busy outside a payment tick");

  // A tick that needs no division shows its result on the next cycle
  a_fast_tick: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !need_div) |=> m_tvalid)
    else $error("result missing after a plain tick");

  // A fault leaves the machine disabled or, with the service button, in maintenance
  a_fault_mode: assert property (@(posedge clk) disable iff (rst)
    (commit && fault) |=> (mode_reg == dms_pkg::MODE_DIS || mode_reg == dms_pkg::MODE_MAINT))
    else $error("fault without disable");

  // A save request comes only from a good dispense or leaving maintenance
  a_save_mode: assert property (@(posedge clk) disable iff (rst)
    (commit && save_req) |=> (mode_reg == dms_pkg::MODE_RET || mode_reg == dms_pkg::MODE_IDLE))
    else $error("save request in wrong mode");

endmodule

`default_nettype wire

// File: tb/sv/tb_dispense_motor_sequencer.sv
// Self-checking testbench for dispense_motor_sequencer: streams poll ticks in,
// predicts each status result and compares it field by field on the way out.
// Depends on dms_pkg and the sequencer RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_dispense_motor_sequencer;
  import dms_pkg::*;

  localparam int HOLD_CYCLES = 300;

  // One poll tick, payment_ok in bit 0
  typedef struct packed {
    logic sub, add, down, up, svc, bottom, ext, top, pay;
  } tick_t;

  // One status result, laid out as on m_tdata
  typedef struct packed {
    logic       pad;
    logic       fault;
    logic       save;
    logic [7:0] stock;
    logic [7:0] duty;
    logic [1:0] dir;
    logic [2:0] mode;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  dispense_motor_sequencer DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #4 clk = ~clk;

  // Shadow of the sequencer state and its registers
  mode_t      pr_mode = MODE_IDLE;
  dir_t       pr_dir = DIR_STOP;
  logic [7:0] pr_lift = '0;
  logic [7:0] pr_stock = INIT_STOCK_RST;
  logic [15:0] pr_elapsed = '0;
  logic [2:0] pr_flags = '0;
  logic [7:0] cfg_max = MAX_STOCK_RST;
  logic [7:0] cfg_ret = RETURN_SPEED_RST;
  logic [15:0] cfg_tmo = TIMEOUT_TICKS_RST;

  tick_t   pending_ticks[$];
  status_t status_due[$];
  logic    tick_taken = 1'b0;
  logic    long_hold = 1'b0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      n_pushed = 0, n_accepted = 0, n_checked = 0, n_errors = 0;
  int      n_dispensed = 0, n_faults = 0, n_saves = 0, n_settings = 0;
  event    hold_off;

  // Lift duty for a given stock: linear map of the clamped count onto 50..240
  function automatic logic [7:0] lift_for_stock(input logic [7:0] count);
    int unsigned hi, s;
    hi = cfg_max;
    s = count;
    if (hi < 2) return SPEED_LOW;
    if (s < 1) s = 1;
    if (s > hi) s = hi;
    return 8'((s - 1) * SPEED_SPAN / (hi - 1) + SPEED_LOW);
  endfunction

  // Advance the shadow state by one tick and return the status it produces
  function automatic status_t next_status(input tick_t t);
    status_t r;
    logic    both;
    r = '0;
    case (pr_mode)
      MODE_IDLE: begin
        if (t.pay) begin
          pr_mode = MODE_DISP;
          pr_lift = lift_for_stock(pr_stock);
          pr_elapsed = '0;
          pr_flags = '0;
          pr_dir = DIR_UP;
        end
        if (pr_stock == 0) begin
          pr_mode = MODE_DIS;
          r.fault = 1'b1;
        end
        if (t.svc) pr_mode = MODE_MAINT;
      end
      MODE_DISP: begin
        both = pr_flags[FLAG_TOP] && pr_flags[FLAG_EXIT];
        if (pr_elapsed != 16'hFFFF) pr_elapsed++;
        if (pr_elapsed < cfg_tmo && !both) begin
          if (t.top) begin
            pr_dir = DIR_STOP;
            pr_flags[FLAG_TOP] = 1'b1;
          end
          if (t.ext) pr_flags[FLAG_EXIT] = 1'b1;
        end else begin
          // dispense over: jars go back down, success only with both sensors
          pr_dir = DIR_DOWN;
          if (both) begin
            pr_mode = MODE_RET;
            if (pr_stock != 0) pr_stock--;
            r.save = 1'b1;
            n_dispensed++;
          end else begin
            pr_mode = MODE_DIS;
            r.fault = 1'b1;
          end
        end
      end
      MODE_RET: begin
        if (t.bottom) begin
          pr_flags[FLAG_BOTTOM] = 1'b1;
          pr_dir = DIR_STOP;
          pr_mode = MODE_IDLE;
        end
      end
      MODE_MAINT: begin
        if (t.up) pr_dir = DIR_UP;
        else if (t.down) pr_dir = DIR_DOWN;
        else pr_dir = DIR_STOP;
        if (t.add && pr_stock < cfg_max) pr_stock++;
        if (t.sub && pr_stock != 0) pr_stock--;
        if (t.svc) begin
          pr_mode = MODE_IDLE;
          pr_flags = '0;
          r.save = 1'b1;
        end
      end
      default: begin
        if (t.svc) pr_mode = MODE_MAINT;
        if (!pr_flags[FLAG_BOTTOM] && t.bottom) begin
          pr_flags[FLAG_BOTTOM] = 1'b1;
          pr_dir = DIR_STOP;
          if (pr_mode != MODE_DIS) pr_mode = MODE_IDLE;
        end
      end
    endcase
    r.mode = pr_mode;
    r.dir = pr_dir;
    r.duty = (pr_dir == DIR_UP) ? pr_lift : (pr_dir == DIR_DOWN) ? cfg_ret : 8'd0;
    r.stock = pr_stock;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, got);
    if (want != got) begin
      n_errors++;
      $display("%0t: tick %0d %s expected %0d, got %0d", $time, n_checked, name, want, got);
    end
  endfunction

  // Check each delivered status, then predict for each accepted tick
  always @(posedge clk) begin : score
    status_t got, want;
    tick_taken = !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (status_due.size() == 0) begin
        n_errors++;
        $display("%0t: status %h arrived with no tick waiting", $time, m_tdata);
      end else begin
        want = status_due.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("motor_dir", want.dir, got.dir);
        check_field("motor_duty", want.duty, got.duty);
        check_field("stock", want.stock, got.stock);
        check_field("save_req", want.save, got.save);
        check_field("fault", want.fault, got.fault);
        n_checked++;
      end
    end
    if (tick_taken) begin
      want = next_status(s_tdata[8:0]);
      if (want.fault) n_faults++;
      if (want.save) n_saves++;
      status_due.push_back(want);
      n_accepted++;
    end
  end

  // Offer the next tick, or idle at random
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || tick_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pending_ticks.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or hold it off entirely
  always @(negedge clk) begin
    if (rst || long_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off so the block backs up into its input
  initial forever begin
    @(hold_off);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d of %0d ticks checked", n_checked, n_pushed);
    $display("Verification failed");
    $finish;
  end

  function automatic logic chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic tick_t tick_of(input logic pay, top, ext, bottom, svc,
                                    up, down, add, sub);
    return {sub, add, down, up, svc, bottom, ext, top, pay};
  endfunction

  task automatic queue_tick(input tick_t t);
    pending_ticks.push_back(t);
    n_pushed++;
  endtask

  task automatic settle();
    wait (n_accepted == n_pushed);
  endtask

  // APB write: setup then access; register lands on the access edge
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAX_STOCK:     cfg_max = val[7:0];
      REG_RETURN_SPEED:  cfg_ret = val[7:0];
      REG_TIMEOUT_TICKS: cfg_tmo = val[15:0];
      default: ;  // initial stock register does not feed the stock count
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain, then load a new register setting and idling profile
  task automatic set_regs(input logic [7:0] top_stock, ret_duty, input logic [15:0] tmo,
                          input logic [7:0] init_stock, input int idle_pct, stall);
    wait (n_checked == n_pushed);
    repeat (4) @(posedge clk);
    cfg_write(REG_MAX_STOCK, {24'd0, top_stock});
    cfg_write(REG_RETURN_SPEED, {24'd0, ret_duty});
    cfg_write(REG_TIMEOUT_TICKS, {16'd0, tmo});
    cfg_write(REG_INITIAL_STOCK, {24'd0, init_stock});
    send_idle_pct = idle_pct;
    stall_pct = stall;
    n_settings++;
  endtask

  // A few ticks shaped for the current mode, now and then plain noise
  task automatic play_batch();
    tick_t t;
    int    n;
    settle();
    n = $urandom_range(1, 3);
    if (chance(10)) begin
      repeat (n) queue_tick(tick_t'(9'($urandom)));
      return;
    end
    repeat (n) begin
      t = tick_t'(9'($urandom));
      case (pr_mode)
        MODE_IDLE: begin
          t.pay = (pr_stock != 0) ? chance(85) : chance(30);
          t.svc = (pr_stock != 0) ? chance(8) : !t.pay;
        end
        MODE_DISP: begin
          t.top = chance(35);
          t.ext = chance(35);
        end
        MODE_RET: t.bottom = chance(40);
        MODE_MAINT: begin
          t.up   = chance(30);
          t.down = chance(30);
          t.add  = chance(50);
          t.sub  = chance(25);
          t.svc  = chance(20);
        end
        default: begin
          t.svc    = chance(35);
          t.bottom = chance(40);
        end
      endcase
      queue_tick(t);
    end
  endtask

  task automatic play_ticks(input int items);
    int stop_at;
    stop_at = n_pushed + items;
    while (n_pushed < stop_at) play_batch();
  endtask

  initial begin
    tick_t t;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty stock, disabled recovery, maintenance buttons, full dispense,
    // payment and service together, all inputs high in each mode
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(0, 0, 0, 1, 0, 0, 0, 0, 0));
    queue_tick(tick_of(0, 0, 0, 0, 1, 0, 0, 0, 0));
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 1));
    queue_tick(tick_of(0, 0, 0, 0, 0, 1, 1, 0, 0));
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 1, 1, 0));
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 1, 1));
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 1, 0));
    queue_tick(tick_of(0, 0, 0, 0, 1, 0, 0, 0, 0));
    queue_tick(tick_of(1, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(0, 1, 0, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(0, 1, 1, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 0, 0, 1, 0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 0, 0, 0, 1, 0, 0, 0, 0));
    queue_tick(tick_of(0, 0, 0, 0, 1, 0, 0, 1, 0));
    queue_tick(tick_of(1, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(0, 0, 1, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 1, 1, 1, 1, 1, 1, 1, 1));
    queue_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tick(tick_of(1, 1, 1, 1, 1, 1, 1, 1, 1));
    queue_tick(tick_of(1, 1, 1, 1, 1, 1, 1, 1, 1));
    queue_tick(tick_of(1, 1, 1, 1, 1, 1, 1, 1, 1));

    // Smallest max stock and timeout: every dispense times out
    set_regs(8'd2, 8'd0, 16'd1, 8'd255, 0, 0);
    play_ticks(200);

    // Largest values; first walk into maintenance and build the stock up
    set_regs(8'd255, 8'd255, 16'hFFFF, 8'd0, 68, 0);
    settle();
    while (pr_mode != MODE_MAINT) begin
      t = '0;
      case (pr_mode)
        MODE_DISP: {t.top, t.ext} = 2'b11;
        MODE_RET:  t.bottom = 1'b1;
        default:   t.svc = 1'b1;
      endcase
      queue_tick(t);
      settle();
    end
    t = '0;
    t.add = 1'b1;
    repeat (40) queue_tick(t);
    t.svc = 1'b1;
    queue_tick(t);
    play_ticks(400);

    // Stock now above max_stock
    set_regs(8'd2, 8'd17, 16'd12, 8'd3, 0, 68);
    play_ticks(400);

    // Random mid-range setting, both sides idling, one long receiver hold-off
    set_regs(8'($urandom_range(3, 254)), 8'($urandom), 16'($urandom_range(2, 40)),
             8'($urandom), 37, 37);
    -> hold_off;
    play_ticks(450);

    // Zero timeout and a max stock below two
    set_regs(8'd1, 8'd200, 16'd0, 8'd1, 0, 0);
    play_ticks(60);

    // Back to the reset setting
    set_regs(MAX_STOCK_RST, RETURN_SPEED_RST, TIMEOUT_TICKS_RST, INIT_STOCK_RST, 0, 0);
    play_ticks(420);

    wait (n_checked == n_pushed);
    repeat (20) @(posedge clk);
    $display("Checked %0d ticks under %0d register settings plus reset values;",
             n_checked, n_settings);
    $display("%0d dispenses completed, %0d faults raised, %0d save requests.",
             n_dispensed, n_faults, n_saves);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
